// ===== src/shist_pkg.sv =====
// Shared types and codes of the scaled histogram unit.
`timescale 1ns / 1ps

package shist_pkg;

	// Function codes of an input word.
	typedef enum logic [1:0] {
		FN_INC   = 2'd0,
		FN_READ  = 2'd1,
		FN_WRITE = 2'd2
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_SKIP  = 2'd2
	} status_t;

	// Configuration register indexes and widths.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_BITS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_DIFF   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WATCHED      = 2'd2;

	// Reset value of channel_bits.
	localparam logic [3:0] CHANNEL_BITS_RESET = 4'd12;

	// Memory operation decided for one word.
	typedef struct packed {
		logic    do_read;
		logic    do_write;
		logic    do_inc;
		status_t status;
	} op_t;

endpackage

// ===== src/scaled_histogram_1d_unit.sv =====
// Top level of the scaled one-dimensional histogram unit.
`timescale 1ns / 1ps

// The unit takes one word per cycle while in_stall is low. Each accepted word
// passes through stage one and then the output register, which presents its
// result word. The bin counters live in one memory with a registered read: a
// word reads its bin in the cycle it is accepted and writes it back when it
// leaves stage one, and a bin written in the same cycle as the next word's read
// is forwarded. While a result word waits under out_stall and stage one is
// full, in_stall is high. After reset a clearing pass zeroes all
// 2^MAX_CHANNEL_BITS bins, one bin a cycle, during which in_stall is high;
// configuration writes are taken at any time but belong in idle periods.
module scaled_histogram_1d_unit #(
	parameter int MAX_CHANNEL_BITS = 12,
	parameter int COUNT_WIDTH      = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [shist_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [shist_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        func,
	input  logic [9:0]                        param_id,
	input  logic signed [31:0]                param_value,
	input  logic                              param_valid,
	input  logic [11:0]                       bin_index,
	input  logic [31:0]                       write_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       read_data,
	output logic [1:0]                        status
);

	localparam int AddrW = MAX_CHANNEL_BITS;
	localparam int Depth = 1 << MAX_CHANNEL_BITS;

	// Configuration registers.
	logic [3:0] channel_bits_q;
	logic [5:0] scale_diff_q;
	logic [9:0] watched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_bits_q <= shist_pkg::CHANNEL_BITS_RESET;
			scale_diff_q   <= 6'd0;
			watched_q      <= 10'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				shist_pkg::CFG_CHANNEL_BITS: channel_bits_q <= cfg_data[3:0];
				shist_pkg::CFG_SCALE_DIFF:   scale_diff_q   <= cfg_data[5:0];
				shist_pkg::CFG_WATCHED:      watched_q      <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Decode of the incoming word.
	shist_pkg::op_t   dec_op;
	logic [AddrW-1:0] dec_addr;

	shist_decode #(
		.MAX_CHANNEL_BITS(MAX_CHANNEL_BITS)
	) u_decode (
		.channel_bits    (channel_bits_q),
		.scale_difference(scale_diff_q),
		.watched_param   (watched_q),
		.func            (func),
		.param_id        (param_id),
		.param_value     (param_value),
		.param_valid     (param_valid),
		.bin_index       (bin_index),
		.op              (dec_op),
		.addr            (dec_addr)
	);

	// Clearing pass after reset.
	logic             clearing_q;
	logic [AddrW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {AddrW{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Pipeline stage one: the word whose bin read is returning.
	logic                   valid_s1;
	shist_pkg::op_t         op_s1;
	logic [AddrW-1:0]       addr_s1;
	logic [COUNT_WIDTH-1:0] wval_s1;
	logic                   fwd_hit_s1;
	logic [COUNT_WIDTH-1:0] fwd_data_s1;

	logic                   out_blocked;
	logic                   s1_adv;
	logic                   accept;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic [COUNT_WIDTH-1:0] old_count;
	logic [COUNT_WIDTH-1:0] new_count;
	logic                   s1_we;

	assign out_blocked = out_valid && out_stall;
	assign s1_adv      = valid_s1 && !out_blocked;
	assign in_stall    = clearing_q || (valid_s1 && out_blocked);
	assign accept      = in_valid && !in_stall;

	// Modify step, with the bin written in the read cycle taken from the bypass.
	assign old_count = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign new_count = op_s1.do_inc ? old_count + 1'b1 : wval_s1;
	assign s1_we     = s1_adv && (op_s1.do_inc || op_s1.do_write);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= dec_op;
			addr_s1     <= dec_addr;
			wval_s1     <= COUNT_WIDTH'(write_value);
			fwd_hit_s1  <= s1_we && (addr_s1 == dec_addr);
			fwd_data_s1 <= new_count;
		end
	end

	// Bin memory: the clearing pass owns the write port until it ends.
	logic                   ram_we;
	logic [AddrW-1:0]       ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;

	assign ram_we    = clearing_q || s1_we;
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : new_count;

	shist_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(Depth)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(dec_addr),
		.rdata(ram_rdata)
	);

	// Output register.
	logic              out_valid_q;
	logic [31:0]       out_data_q;
	shist_pkg::status_t out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q   <= op_s1.do_read ? 32'(old_count) : 32'd0;
			out_status_q <= op_s1.status;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_data_q;
	assign status    = out_status_q;

	// No word sits in the pipeline while the clearing pass runs.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1)
		else $error("word in stage one during clearing pass");

	// A new result word always comes from stage one.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result word without a word in stage one");

	// Only a successful read returns a nonzero count.
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == shist_pkg::ST_RANGE ||
			out_status_q == shist_pkg::ST_SKIP)) |-> (out_data_q == 32'd0))
		else $error("nonzero read data on a failed or skipped word");

	// A held stage one keeps its address, so its read data stays valid.
	a_hold_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_blocked) |=> $stable(addr_s1))
		else $error("stage one address changed while held");

endmodule

// ===== src/shist_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module shist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/shist_decode.sv =====
// Input word decode: value scaling, bin selection and range checks.
`timescale 1ns / 1ps

module shist_decode #(
	parameter int MAX_CHANNEL_BITS = 12
) (
	input  logic [3:0]                  channel_bits,
	input  logic [5:0]                  scale_difference,
	input  logic [9:0]                  watched_param,
	input  logic [1:0]                  func,
	input  logic [9:0]                  param_id,
	input  logic signed [31:0]          param_value,
	input  logic                        param_valid,
	input  logic [11:0]                 bin_index,
	output shist_pkg::op_t              op,
	output logic [MAX_CHANNEL_BITS-1:0] addr
);

	localparam logic [4:0] MaxBits = 5'(MAX_CHANNEL_BITS);

	logic [4:0]  act_bits;
	logic [5:0]  left_n;
	logic [31:0] scaled;
	logic        bin_ok;
	logic        idx_ok;
	logic        watched_hit;

	// Active size is clamped to the memory depth.
	assign act_bits = (5'(channel_bits) > MaxBits) ? MaxBits : 5'(channel_bits);

	// Positive shift is arithmetic right; otherwise left by the negated amount.
	assign left_n = 6'(-$signed(scale_difference));
	always_comb begin
		if ($signed(scale_difference) > 6'sd0) begin
			scaled = 32'(param_value >>> scale_difference[4:0]);
		end else begin
			scaled = 32'(param_value) << left_n;
		end
	end

	// A value below the active size has no bits at or above act_bits.
	assign bin_ok      = (scaled >> act_bits) == 32'd0;
	assign idx_ok      = (bin_index >> act_bits) == 12'd0;
	assign watched_hit = param_valid && (param_id == watched_param);

	// Choose the memory operation and the status of the word.
	always_comb begin
		op.do_read  = 1'b0;
		op.do_write = 1'b0;
		op.do_inc   = 1'b0;
		op.status   = shist_pkg::ST_SKIP;
		addr        = MAX_CHANNEL_BITS'(bin_index);
		case (func)
			shist_pkg::FN_INC: begin
				addr = MAX_CHANNEL_BITS'(scaled);
				if (watched_hit && bin_ok) begin
					op.do_inc = 1'b1;
					op.status = shist_pkg::ST_DONE;
				end
			end
			shist_pkg::FN_READ: begin
				if (idx_ok) begin
					op.do_read = 1'b1;
					op.status  = shist_pkg::ST_DONE;
				end else begin
					op.status = shist_pkg::ST_RANGE;
				end
			end
			shist_pkg::FN_WRITE: begin
				if (idx_ok) begin
					op.do_write = 1'b1;
					op.status   = shist_pkg::ST_DONE;
				end else begin
					op.status = shist_pkg::ST_RANGE;
				end
			end
			default: begin
				op.status = shist_pkg::ST_SKIP;
			end
		endcase
	end

endmodule
